>>> hdl/psmf_pkg.sv
package psmf_pkg;

    // Status word layout
    localparam int NBITS      = 12;
    localparam int BIT_EARTH  = 4;
    localparam int BIT_TEMP   = 5;
    localparam int BIT_UNK0   = 6;
    localparam int BIT_RIGHT  = 10;
    localparam int BIT_LEFT   = 11;
    localparam int NWIRES     = 4;

    localparam int CNT_W      = 4;

    typedef logic [NBITS-1:0] status_t;
    typedef logic [7:0]       presence_t;

    // Rotation codes
    localparam logic [1:0] ROT_RIGHT = 2'd1;
    localparam logic [1:0] ROT_LEFT  = 2'd2;

    // LED codes
    localparam logic [1:0] LED_LOST  = 2'd0;
    localparam logic [1:0] LED_RIGHT = 2'd1;
    localparam logic [1:0] LED_LEFT  = 2'd2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PRESENCE_LIMIT = 2'd0,
        CFG_TEMP_SET       = 2'd1,
        CFG_TEMP_CLEAR     = 2'd2,
        CFG_VOTE_THRESHOLD = 2'd3
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [7:0]        PRESENCE_LIMIT_RST = 8'd10;
    localparam logic signed [7:0] TEMP_SET_RST       = 8'sd60;
    localparam logic signed [7:0] TEMP_CLEAR_RST     = 8'sd57;
    localparam logic [3:0]        VOTE_THRESHOLD_RST = 4'd7;

    typedef struct packed {
        logic [7:0]        presence_limit;
        logic signed [7:0] temp_set;
        logic signed [7:0] temp_clear;
        logic [3:0]        vote_threshold;
    } cfg_t;

endpackage

>>> hdl/psmf_raw.sv
module psmf_raw (
    input  psmf_pkg::cfg_t      cfg,
    input  logic [7:0]          phase1_presence,
    input  logic [7:0]          phase2_presence,
    input  logic [7:0]          phase3_presence,
    input  logic [7:0]          neutral_presence,
    input  logic                earth_present,
    input  logic signed [7:0]   temp_degrees,
    input  logic [1:0]          rotation,
    input  logic                latch,
    output logic                latch_next,
    output psmf_pkg::status_t   raw
);
    import psmf_pkg::*;

    presence_t presence [NWIRES];
    logic      keep_latch;

    assign presence[0] = phase1_presence;
    assign presence[1] = phase2_presence;
    assign presence[2] = phase3_presence;
    assign presence[3] = neutral_presence;

    // Clear test comes first, then set test
    assign keep_latch = latch && !(temp_degrees < cfg.temp_clear);
    assign latch_next = (temp_degrees > cfg.temp_set) || keep_latch;

    // Build the raw status word
    always_comb
    begin
        raw = '0;
        for (int w = 0; w < NWIRES; w++)
        begin
            if (presence[w] < cfg.presence_limit)
            begin
                raw[w] = 1'b1;
                if (presence[w] != 8'd0)
                begin
                    raw[BIT_UNK0 + w] = 1'b1;
                end
            end
        end
        raw[BIT_EARTH] = !earth_present;
        raw[BIT_TEMP]  = latch_next;
        if (raw == '0)
        begin
            if (rotation == ROT_RIGHT)
            begin
                raw[BIT_RIGHT] = 1'b1;
            end
            else if (rotation == ROT_LEFT)
            begin
                raw[BIT_LEFT] = 1'b1;
            end
        end
    end

endmodule

>>> hdl/phase_status_majority_filter.sv
// Phase status majority filter.
// Input channel (in_valid / in_stall) carries one measurement tick: four
// presence counts, the earth flag, temperature and rotation. Output channel
// (out_valid / out_stall) returns one transaction per tick: the filtered
// 12-bit status word and the LED code. Configuration writes use cfg_valid /
// cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// A tick taken at an edge has its result in the output register from that
// edge on. Throughput is one tick per cycle unless the receiver stalls; the
// single combinational pass from the input ports to the result register
// (raw word, counter increment and majority compare) sets that figure.
// When the receiver stalls, the result register holds and in_stall rises,
// so no new tick is taken until the pending result is delivered; a result
// taken in the same cycle frees the register for the next tick.
// Reset clears the configuration to defaults, the counters, the window
// position and the over-temperature latch, and restarts the first window,
// during which raw status words are passed through unfiltered.
module phase_status_majority_filter #(
    parameter int WINDOW = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          phase1_presence,
    input  logic [7:0]          phase2_presence,
    input  logic [7:0]          phase3_presence,
    input  logic [7:0]          neutral_presence,
    input  logic                earth_present,
    input  logic signed [7:0]   temp_degrees,
    input  logic [1:0]          rotation,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [11:0]         status_word,
    output logic [1:0]          led_state,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  psmf_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_data
);
    import psmf_pkg::*;

    localparam int POS_W = $clog2(WINDOW + 1);

    cfg_t                cfg_reg;
    logic                latch_reg;
    logic                latch_next;
    logic [CNT_W-1:0]    cnt_reg  [NBITS];
    logic [CNT_W-1:0]    cnt_next [NBITS];
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_inc;
    logic                first_reg;
    logic                first_next;
    status_t             filtered_reg;
    status_t             filtered_next;
    status_t             raw;
    status_t             vote;
    logic                window_end;
    logic                accept;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    logic [1:0]          led_reg;
    logic [1:0]          led_next;

    // Handshake
    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign status_word = status_reg;
    assign led_state   = led_reg;
    assign out_valid_next = accept || (out_valid_reg && out_stall);

    psmf_raw u_raw (
        .cfg              (cfg_reg),
        .phase1_presence  (phase1_presence),
        .phase2_presence  (phase2_presence),
        .phase3_presence  (phase3_presence),
        .neutral_presence (neutral_presence),
        .earth_present    (earth_present),
        .temp_degrees     (temp_degrees),
        .rotation         (rotation),
        .latch            (latch_reg),
        .latch_next       (latch_next),
        .raw              (raw)
    );

    // Advance the window position
    assign pos_inc    = pos_reg + POS_W'(1);
    assign window_end = (pos_inc >= POS_W'(WINDOW));

    // Count raw bits and vote at the window end
    always_comb
    begin
        vote = '0;
        for (int i = 0; i < NBITS; i++)
        begin
            cnt_next[i] = cnt_reg[i] + CNT_W'(raw[i]);
        end
        for (int i = 0; i < BIT_RIGHT; i++)
        begin
            vote[i] = (cnt_next[i] > cfg_reg.vote_threshold);
        end
        if (vote == '0)
        begin
            if (cnt_next[BIT_RIGHT] >= cnt_next[BIT_LEFT])
            begin
                vote[BIT_RIGHT] = 1'b1;
            end
            else
            begin
                vote[BIT_LEFT] = 1'b1;
            end
        end
    end

    // Select the reported word
    always_comb
    begin
        first_next    = first_reg && !window_end;
        filtered_next = window_end ? vote : filtered_reg;
        if (first_next)
        begin
            filtered_next = raw;
        end
        if (filtered_next[BIT_RIGHT])
        begin
            led_next = LED_RIGHT;
        end
        else if (filtered_next[BIT_LEFT])
        begin
            led_next = LED_LEFT;
        end
        else
        begin
            led_next = LED_LOST;
        end
    end

    // Hold configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.presence_limit <= PRESENCE_LIMIT_RST;
            cfg_reg.temp_set       <= TEMP_SET_RST;
            cfg_reg.temp_clear     <= TEMP_CLEAR_RST;
            cfg_reg.vote_threshold <= VOTE_THRESHOLD_RST;
            latch_reg     <= 1'b0;
            pos_reg       <= '0;
            first_reg     <= 1'b1;
            filtered_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NBITS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PRESENCE_LIMIT: cfg_reg.presence_limit <= cfg_data;
                    CFG_TEMP_SET:       cfg_reg.temp_set       <= cfg_data;
                    CFG_TEMP_CLEAR:     cfg_reg.temp_clear     <= cfg_data;
                    CFG_VOTE_THRESHOLD: cfg_reg.vote_threshold <= cfg_data[3:0];
                    default:            ;
                endcase
            end
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                latch_reg    <= latch_next;
                pos_reg      <= window_end ? '0 : pos_inc;
                first_reg    <= first_next;
                filtered_reg <= filtered_next;
                for (int i = 0; i < NBITS; i++)
                begin
                    cnt_reg[i] <= window_end ? '0 : cnt_next[i];
                end
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= filtered_next;
            led_reg    <= led_next;
        end
    end

    // A stall toward the sender only comes from a pending result
    a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("in_stall without a pending result");

    // Every accepted tick produces a result
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted tick produced no result");

    // Window position stays inside the window
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(WINDOW))
        else $error("window position out of range");

    // Direction bits never appear together with error bits
    a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg[BIT_RIGHT-1:0] != '0)
            |-> (status_reg[BIT_LEFT:BIT_RIGHT] == 2'b00))
        else $error("direction bit set with an error bit");

    // LED code follows the status word
    a_led_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((led_reg == LED_RIGHT) == status_reg[BIT_RIGHT]))
        else $error("led_state disagrees with status_word");

endmodule

>>> verif/tb_phase_status_majority_filter.sv
module tb_phase_status_majority_filter;

    timeunit 1ns;
    timeprecision 1ps;

    import psmf_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int WINDOW_LEN  = 14;
    localparam int HOLD_LEN    = 40;
    localparam int HOLD_AT     = 80;
    localparam int STUCK_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    // Rotation codes that the package leaves unnamed
    localparam logic [1:0] ROT_NONE   = 2'd0;
    localparam logic [1:0] ROT_UNUSED = 2'd3;

    typedef struct packed {
        logic [NWIRES-1:0][7:0] presence;
        logic                   earth;
        logic signed [7:0]      temp;
        logic [1:0]             rot;
    } tick_t;

    typedef struct packed {
        status_t    status;
        logic [1:0] led;
    } status_expect_t;

    // Block ports
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          phase1_presence = '0;
    logic [7:0]          phase2_presence = '0;
    logic [7:0]          phase3_presence = '0;
    logic [7:0]          neutral_presence = '0;
    logic                earth_present = 1'b0;
    logic signed [7:0]   temp_degrees = '0;
    logic [1:0]          rotation = ROT_NONE;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [11:0]         status_word;
    logic [1:0]          led_state;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    cfg_index_t          cfg_index = CFG_PRESENCE_LIMIT;
    logic [7:0]          cfg_data = '0;

    // Predictor copy of configuration and filter state
    logic [7:0]          presence_limit_q = PRESENCE_LIMIT_RST;
    logic signed [7:0]   temp_set_q       = TEMP_SET_RST;
    logic signed [7:0]   temp_clear_q     = TEMP_CLEAR_RST;
    logic [3:0]          vote_threshold_q = VOTE_THRESHOLD_RST;
    logic                overtemp_q       = 1'b0;
    logic [CNT_W-1:0]    vote_cnt [NBITS];
    logic [3:0]          window_pos       = '0;
    logic                first_window_q   = 1'b1;
    status_t             filtered_q       = '0;

    tick_t               tick_q [$];
    status_expect_t      status_expect_q [$];
    tick_t               drive_tick;

    int                  gap_left      = 0;
    int                  stall_left    = 0;
    int                  hold_left     = 0;
    bit                  hold_done     = 1'b0;
    bit                  idle_on       = 1'b1;
    int                  results_seen  = 0;
    int                  mismatch_count = 0;
    int                  stuck_cycles  = 0;

    phase_status_majority_filter #(
        .WINDOW(WINDOW_LEN)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .phase1_presence  (phase1_presence),
        .phase2_presence  (phase2_presence),
        .phase3_presence  (phase3_presence),
        .neutral_presence (neutral_presence),
        .earth_present    (earth_present),
        .temp_degrees     (temp_degrees),
        .rotation         (rotation),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status_word      (status_word),
        .led_state        (led_state),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        foreach (vote_cnt[i])
            vote_cnt[i] = '0;
    end

    function automatic logic signed [7:0] clamp8(input int v);
        if (v > 127)
            return 8'sd127;
        if (v < -128)
            return -8'sd128;
        return 8'(v);
    endfunction

    // Build the raw word, update the window tally and queue the expected transaction
    function automatic void predict_status(input tick_t t);
        status_t        raw;
        status_t        vote;
        status_expect_t exp_item;
        int             w;
        int             i;

        raw = '0;
        for (w = 0; w < NWIRES; w++)
        begin
            if (t.presence[w] < presence_limit_q)
            begin
                raw[w] = 1'b1;
                if (t.presence[w] != 8'd0)
                    raw[BIT_UNK0 + w] = 1'b1;
            end
        end
        if (!t.earth)
            raw[BIT_EARTH] = 1'b1;

        // Clear is tested before set
        if ($signed(t.temp) < temp_clear_q)
            overtemp_q = 1'b0;
        if ($signed(t.temp) > temp_set_q || overtemp_q)
        begin
            raw[BIT_TEMP] = 1'b1;
            overtemp_q    = 1'b1;
        end

        // Direction only on a clean word
        if (raw == '0)
        begin
            if (t.rot == ROT_RIGHT)
                raw[BIT_RIGHT] = 1'b1;
            else if (t.rot == ROT_LEFT)
                raw[BIT_LEFT] = 1'b1;
        end

        for (i = 0; i < NBITS; i++)
            if (raw[i])
                vote_cnt[i] = vote_cnt[i] + 1'b1;
        window_pos = window_pos + 1'b1;

        // Vote at the end of the window
        if (window_pos >= WINDOW_LEN)
        begin
            window_pos = '0;
            vote = '0;
            for (i = 0; i < BIT_RIGHT; i++)
                if (vote_cnt[i] > vote_threshold_q)
                    vote[i] = 1'b1;
            if (vote == '0)
            begin
                if (vote_cnt[BIT_RIGHT] >= vote_cnt[BIT_LEFT])
                    vote[BIT_RIGHT] = 1'b1;
                else
                    vote[BIT_LEFT] = 1'b1;
            end
            filtered_q = vote;
            for (i = 0; i < NBITS; i++)
                vote_cnt[i] = '0;
            first_window_q = 1'b0;
        end

        if (first_window_q)
            filtered_q = raw;

        exp_item.status = filtered_q;
        if (filtered_q[BIT_RIGHT])
            exp_item.led = LED_RIGHT;
        else if (filtered_q[BIT_LEFT])
            exp_item.led = LED_LEFT;
        else
            exp_item.led = LED_LOST;
        status_expect_q.push_back(exp_item);
    endfunction

    function automatic tick_t make_tick(input logic [7:0] p1, input logic [7:0] p2,
                                        input logic [7:0] p3, input logic [7:0] pn,
                                        input logic earth, input logic signed [7:0] temp,
                                        input logic [1:0] rot);
        tick_t t;
        t.presence[0] = p1;
        t.presence[1] = p2;
        t.presence[2] = p3;
        t.presence[3] = pn;
        t.earth       = earth;
        t.temp        = temp;
        t.rot         = rot;
        return t;
    endfunction

    // Draw one tick; fault_pct sets how often a wire or earth goes bad
    function automatic tick_t random_tick(input int fault_pct, input logic [1:0] favored);
        tick_t t;
        int    w;

        for (w = 0; w < NWIRES; w++)
        begin
            if ($urandom_range(0, 9) == 0)
                t.presence[w] = 8'($urandom);
            else if ($urandom_range(0, 99) < fault_pct && presence_limit_q != 8'd0)
                t.presence[w] = $urandom_range(0, 1) ? 8'd0
                                : 8'($urandom_range(0, int'(presence_limit_q) - 1));
            else
                t.presence[w] = 8'($urandom_range(int'(presence_limit_q), 255));
        end

        if ($urandom_range(0, 19) == 0)
            t.earth = 1'($urandom);
        else
            t.earth = ($urandom_range(0, 99) < fault_pct) ? 1'b0 : 1'b1;

        if (fault_pct == 0 && temp_clear_q != -8'sd128)
            t.temp = clamp8(int'(temp_clear_q) - 1 - int'($urandom_range(0, 20)));
        else if ($urandom_range(0, 3) == 0)
            t.temp = 8'($urandom);
        else
            t.temp = clamp8(int'($urandom_range(0, 1) ? temp_set_q : temp_clear_q)
                            + int'($urandom_range(0, 8)) - 4);

        t.rot = ($urandom_range(0, 4) < 3) ? favored : 2'($urandom_range(0, 3));
        return t;
    endfunction

    // Driver: hold the payload while stalled, advance on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_status(drive_tick);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (tick_q.size() > 0)
                begin
                    drive_tick = tick_q.pop_front();
                    phase1_presence  <= drive_tick.presence[0];
                    phase2_presence  <= drive_tick.presence[1];
                    phase3_presence  <= drive_tick.presence[2];
                    neutral_presence <= drive_tick.presence[3];
                    earth_present    <= drive_tick.earth;
                    temp_degrees     <= drive_tick.temp;
                    rotation         <= drive_tick.rot;
                    in_valid         <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 4);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each delivered transaction, then pick the next stall
    always @(posedge clk)
    begin
        status_expect_t exp_item;

        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (status_expect_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result %0d: word %03h led %0d",
                                 results_seen, status_word, led_state);
                end
                else
                begin
                    exp_item = status_expect_q.pop_front();
                    if (status_word !== exp_item.status || led_state !== exp_item.led)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("result %0d: expected word %03h led %0d, got word %03h led %0d",
                                     results_seen, exp_item.status, exp_item.led,
                                     status_word, led_state);
                    end
                end
            end

            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                // Long hold-off so the block backs up into its input
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("no transaction for %0d cycles", stuck_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PRESENCE_LIMIT: presence_limit_q = value;
            CFG_TEMP_SET:       temp_set_q       = value;
            CFG_TEMP_CLEAR:     temp_clear_q     = value;
            CFG_VOTE_THRESHOLD: vote_threshold_q = value[3:0];
            default: ;
        endcase
    endtask

    // Wait until every tick is taken and every result delivered
    task automatic wait_drained();
        @(posedge clk);
        while (tick_q.size() != 0 || in_valid || status_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] limit, input logic [7:0] tset,
                             input logic [7:0] tclear, input logic [7:0] vote,
                             input int n_windows);
        int         k;
        int         j;
        int         fault_pct;
        logic [1:0] favored;

        write_reg(CFG_PRESENCE_LIMIT, limit);
        write_reg(CFG_TEMP_SET, tset);
        write_reg(CFG_TEMP_CLEAR, tclear);
        write_reg(CFG_VOTE_THRESHOLD, vote);

        // Give each window its own fault level and dominant rotation
        for (k = 0; k < n_windows; k++)
        begin
            case ($urandom_range(0, 5))
                0, 1:    fault_pct = 0;
                2:       fault_pct = 5;
                3:       fault_pct = 30;
                4:       fault_pct = 60;
                default: fault_pct = 95;
            endcase
            favored = $urandom_range(0, 1) ? ROT_RIGHT : ROT_LEFT;
            for (j = 0; j < WINDOW_LEN; j++)
                tick_q.push_back(random_tick(fault_pct, favored));
        end
        wait_drained();
    endtask

    initial
    begin
        int               p;
        logic signed [7:0] tset;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks at reset configuration, through the first window end
        tick_q.push_back(make_tick(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'sd20, ROT_RIGHT));
        tick_q.push_back(make_tick(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, -8'sd128, ROT_LEFT));
        tick_q.push_back(make_tick(8'd9, 8'd10, 8'd1, 8'd255, 1'b1, 8'sd0, ROT_RIGHT));
        tick_q.push_back(make_tick(8'd10, 8'd10, 8'd10, 8'd10, 1'b1, 8'sd127, ROT_NONE));
        tick_q.push_back(make_tick(8'd200, 8'd200, 8'd200, 8'd200, 1'b1, 8'sd58, ROT_RIGHT));
        tick_q.push_back(make_tick(8'd200, 8'd200, 8'd200, 8'd200, 1'b1, 8'sd57, ROT_RIGHT));
        tick_q.push_back(make_tick(8'd200, 8'd200, 8'd200, 8'd200, 1'b1, 8'sd56, ROT_RIGHT));
        tick_q.push_back(make_tick(8'd200, 8'd200, 8'd200, 8'd200, 1'b1, 8'sd60, ROT_LEFT));
        tick_q.push_back(make_tick(8'd200, 8'd200, 8'd200, 8'd200, 1'b1, 8'sd61, ROT_LEFT));
        tick_q.push_back(make_tick(8'd170, 8'd85, 8'd170, 8'd85, 1'b1, 8'sd56, ROT_UNUSED));
        tick_q.push_back(make_tick(8'd85, 8'd170, 8'd85, 8'd170, 1'b1, -8'sd1, ROT_LEFT));
        tick_q.push_back(make_tick(8'd128, 8'd127, 8'd64, 8'd32, 1'b1, -8'sd86, ROT_NONE));
        tick_q.push_back(make_tick(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'sd85, ROT_RIGHT));
        tick_q.push_back(make_tick(8'd0, 8'd255, 8'd9, 8'd1, 1'b1, 8'sd10, ROT_LEFT));
        tick_q.push_back(make_tick(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'sd20, ROT_LEFT));
        tick_q.push_back(make_tick(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'sd20, ROT_NONE));
        tick_q.push_back(make_tick(8'd5, 8'd5, 8'd5, 8'd5, 1'b0, 8'sd100, ROT_RIGHT));
        tick_q.push_back(make_tick(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'sd30, ROT_UNUSED));
        tick_q.push_back(make_tick(8'd16, 8'd32, 8'd64, 8'd128, 1'b1, 8'sd40, ROT_RIGHT));
        tick_q.push_back(make_tick(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'sd20, ROT_LEFT));
        tick_q.push_back(make_tick(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'sd20, ROT_LEFT));
        tick_q.push_back(make_tick(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'sd20, ROT_RIGHT));
        wait_drained();

        // Reset values, then the extremes of every register
        run_phase(8'd10, 8'd60, 8'd57, 8'd7, 9);
        run_phase(8'd0, 8'h80, 8'h7f, 8'd0, 5);
        run_phase(8'd255, 8'h7f, 8'h80, {4'($urandom), 4'd15}, 5);
        run_phase(8'd1, 8'd0, 8'd0, 8'd14, 3);

        // Random settings; the last phase runs without idling
        for (p = 0; p < 4; p++)
        begin
            if (p == 3)
                idle_on = 1'b0;
            tset = 8'($urandom);
            run_phase($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(1, 40)),
                      tset,
                      $urandom_range(0, 4) == 0 ? 8'($urandom)
                          : clamp8(int'(tset) - int'($urandom_range(0, 10))),
                      {4'($urandom), 4'($urandom_range(0, 15))},
                      6);
        end

        repeat (4) @(posedge clk);
        if (status_expect_q.size() != 0)
            $display("%0d expected results never arrived", status_expect_q.size());
        if (mismatch_count == 0 && status_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
